// File: rtl/core/td0gta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// td0gta_pkg: shared types and constants of the grid tuning agent
// Field widths, register indexes, reset values and the sequencer states.
// ----------------------------------------------------------------------------
package td0gta_pkg;

   localparam int PERF_W    = 16;
   localparam int PCT_W     = 7;
   localparam int PICK_W    = 8;
   localparam int ACT_W     = 4;
   localparam int LVL_OUT_W = 2;
   localparam int VAL_W     = 24;
   localparam int CSR_W     = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_DISCOUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPLORE    = 2'd2;

   localparam logic [7:0]       DISCOUNT_RST   = 8'd179;
   localparam logic [7:0]       LEARN_RATE_RST = 8'd26;
   localparam logic [PCT_W-1:0] EXPLORE_RST    = 7'd20;

   localparam logic [7:0] GREEDY_BOUND = 8'd100;
   localparam logic [3:0] DIV_STEPS    = 4'd8;

   localparam logic signed [28:0] VAL_MAX = 29'sd8388607;
   localparam logic signed [28:0] VAL_MIN = -29'sd8388608;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_PICK,
      ST_READ_NEXT,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_UPDATE,
      ST_DONE
   } state_type;

endpackage

// File: rtl/core/td0gta_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// td0gta request / response channels
// Valid-ready channels carrying a performance request and an action response.
// ----------------------------------------------------------------------------
interface td0gta_req_if;
   logic                              valid;
   logic                              ready;
   logic [td0gta_pkg::PERF_W-1:0]     performance;
   logic [td0gta_pkg::PCT_W-1:0]      random_percent;
   logic [td0gta_pkg::PICK_W-1:0]     random_pick;

   modport source (output valid, performance, random_percent, random_pick, input ready);
   modport sink   (input valid, performance, random_percent, random_pick, output ready);
endinterface

interface td0gta_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [td0gta_pkg::ACT_W-1:0]      action;
   logic                              was_greedy;
   logic [td0gta_pkg::LVL_OUT_W-1:0]  knob0_level;
   logic [td0gta_pkg::LVL_OUT_W-1:0]  knob1_level;
   logic [td0gta_pkg::LVL_OUT_W-1:0]  knob2_level;
   logic [td0gta_pkg::LVL_OUT_W-1:0]  knob3_level;

   modport source (output valid, action, was_greedy, knob0_level, knob1_level,
                   knob2_level, knob3_level, input ready);
   modport sink   (input valid, action, was_greedy, knob0_level, knob1_level,
                   knob2_level, knob3_level, output ready);
endinterface

// File: rtl/core/td0_grid_tuning_agent.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// td0_grid_tuning_agent: TD(0) epsilon-greedy tuner over a grid of knobs
//
// Each request carries a performance sample and two random values. The block
// picks stay or a one-level move of one knob (greedy from the value table, or
// a random allowed move), applies a TD(0) update to the entry it leaves and
// answers with the action and the new knob levels.
// Channels: req_port (sink) and rsp_port (source), valid/ready; csr_* writes
// discount, learn rate and explore percent. The user must write them only while
// the block is idle; the block itself does not enforce it. One request is
// handled at a time. The scan of 1 + 2*NUM_KNOBS actions issues one
// value-table read per cycle; one read of the chosen target, three
// multiply/add stages, the write-back and the response register follow.
// Exploring adds a walk through the allowed moves, with the divider for the
// random pick running in parallel. The single read port sets the scan rate.
// Reset: a clearing pass writes zero to all LEVELS**NUM_KNOBS entries, one per
// cycle; requests wait, CSR writes are taken.
// Stall: the response sits in an output register; while it is not taken the
// block still accepts and works on the next request, and holds its next
// response until the register frees.
// ----------------------------------------------------------------------------
module td0_grid_tuning_agent #(
   parameter int NUM_KNOBS = 4,
   parameter int LEVELS    = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   td0gta_req_if.sink                       req_port,
   td0gta_rsp_if.source                     rsp_port,
   input  logic                             csr_wr_en,
   input  logic [td0gta_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [td0gta_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int DEPTH  = LEVELS ** NUM_KNOBS;
   localparam int IW     = $clog2(DEPTH);
   localparam int LW     = $clog2(LEVELS);
   localparam int NA     = 1 + 2 * NUM_KNOBS;
   localparam int VAL_W  = td0gta_pkg::VAL_W;
   localparam int ACT_W  = td0gta_pkg::ACT_W;
   localparam int PERF_W = td0gta_pkg::PERF_W;

   td0gta_pkg::state_type state_ff, state_in;

   logic [ACT_W-1:0]         act_ff, act_in;
   logic                     rd_pend_ff, rd_pend_in;
   logic [ACT_W-1:0]         rd_act_ff, rd_act_in;
   logic [ACT_W-1:0]         best_act_ff, best_act_in;
   logic signed [VAL_W-1:0]  best_val_ff, best_val_in;
   logic signed [VAL_W-1:0]  cur_val_ff, cur_val_in;
   logic [ACT_W-1:0]         chosen_ff, chosen_in;
   logic                     greedy_ff, greedy_in;
   logic [PERF_W-1:0]        perf_ff, perf_in;
   logic [PERF_W-1:0]        last_perf_ff, last_perf_in;
   logic [3:0]               count_ff, count_in;
   logic [3:0]               rem_ff, rem_in;
   logic [td0gta_pkg::PICK_W-1:0] dvd_ff, dvd_in;
   logic [3:0]               div_cnt_ff, div_cnt_in;
   logic [IW-1:0]            next_idx_ff, next_idx_in;
   logic [IW-1:0]            cur_idx_ff, cur_idx_in;
   logic [IW-1:0]            clr_idx_ff, clr_idx_in;
   logic signed [32:0]       prod1_ff, prod1_in;
   logic signed [26:0]       diff_ff, diff_in;
   logic signed [35:0]       prod2_ff, prod2_in;
   logic [LW-1:0]            levels_ff [NUM_KNOBS];
   logic [LW-1:0]            levels_in [NUM_KNOBS];
   logic [7:0]               disc_ff, disc_in;
   logic [7:0]               lr_ff, lr_in;
   logic [td0gta_pkg::PCT_W-1:0] expl_ff, expl_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ACT_W-1:0]         rsp_action_ff, rsp_action_in;
   logic                     rsp_greedy_ff, rsp_greedy_in;
   logic [td0gta_pkg::LVL_OUT_W-1:0] rsp_knob_ff [4];
   logic [td0gta_pkg::LVL_OUT_W-1:0] rsp_knob_in [4];

   logic [IW-1:0]            stride_w [NUM_KNOBS];
   logic                     req_fire;
   logic                     div_done;
   logic                     pick_hit;
   logic                     scan_last;
   logic                     rsp_free;

   logic                     ram_we;
   logic [IW-1:0]            ram_waddr;
   logic [VAL_W-1:0]         ram_wdata;
   logic [IW-1:0]            ram_raddr;
   logic [VAL_W-1:0]         ram_rdata;
   logic signed [VAL_W-1:0]  rd_sdata;

   for (genvar g = 0; g < NUM_KNOBS; g++) begin : g_stride
      assign stride_w[g] = IW'(LEVELS ** g);
   end

   function automatic logic act_allowed(input logic [ACT_W-1:0] a);
      logic             ok;
      logic [ACT_W-1:0] k;
      ok = (a == '0);
      k  = (a - ACT_W'(1)) >> 1;
      for (int i = 0; i < NUM_KNOBS; i++) begin
         if (a != '0 && k == ACT_W'(i)) begin
            ok = a[0] ? (levels_ff[i] != LW'(LEVELS - 1)) : (levels_ff[i] != '0);
         end
      end
      return ok;
   endfunction

   function automatic logic [IW-1:0] target_idx(input logic [ACT_W-1:0] a);
      logic [IW-1:0]    t;
      logic [ACT_W-1:0] k;
      t = cur_idx_ff;
      k = (a - ACT_W'(1)) >> 1;
      for (int i = 0; i < NUM_KNOBS; i++) begin
         if (a != '0 && k == ACT_W'(i)) begin
            t = a[0] ? cur_idx_ff + stride_w[i] : cur_idx_ff - stride_w[i];
         end
      end
      return t;
   endfunction

   assign req_port.ready = (state_ff == td0gta_pkg::ST_IDLE);
   assign req_fire       = req_port.valid && req_port.ready;
   assign div_done       = (div_cnt_ff == td0gta_pkg::DIV_STEPS);
   assign pick_hit       = div_done && act_allowed(act_ff) && (rem_ff == '0);
   assign scan_last      = (act_ff == ACT_W'(NA - 1));
   assign rsp_free       = !rsp_valid_ff || rsp_port.ready;
   assign rd_sdata       = $signed(ram_rdata);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         td0gta_pkg::ST_CLEAR: begin
            if (clr_idx_ff == IW'(DEPTH - 1)) begin
               state_in = td0gta_pkg::ST_IDLE;
            end
         end
         td0gta_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = td0gta_pkg::ST_SCAN;
            end
         end
         td0gta_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = td0gta_pkg::ST_SCAN_LAST;
            end
         end
         td0gta_pkg::ST_SCAN_LAST: begin
            state_in = greedy_ff ? td0gta_pkg::ST_READ_NEXT : td0gta_pkg::ST_PICK;
         end
         td0gta_pkg::ST_PICK: begin
            if (pick_hit) begin
               state_in = td0gta_pkg::ST_READ_NEXT;
            end
         end
         td0gta_pkg::ST_READ_NEXT: state_in = td0gta_pkg::ST_MUL1;
         td0gta_pkg::ST_MUL1:      state_in = td0gta_pkg::ST_MUL2;
         td0gta_pkg::ST_MUL2:      state_in = td0gta_pkg::ST_MUL3;
         td0gta_pkg::ST_MUL3:      state_in = td0gta_pkg::ST_UPDATE;
         td0gta_pkg::ST_UPDATE:    state_in = td0gta_pkg::ST_DONE;
         td0gta_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = td0gta_pkg::ST_IDLE;
            end
         end
         default: state_in = td0gta_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic [3:0]         cnt;
      logic [4:0]         trial;
      logic signed [16:0] reward;
      logic signed [25:0] sample;
      logic signed [28:0] upd;
      logic [ACT_W-1:0]   k;

      act_in        = act_ff;
      rd_pend_in    = 1'b0;
      rd_act_in     = act_ff;
      best_act_in   = best_act_ff;
      best_val_in   = best_val_ff;
      cur_val_in    = cur_val_ff;
      chosen_in     = chosen_ff;
      greedy_in     = greedy_ff;
      perf_in       = perf_ff;
      last_perf_in  = last_perf_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      div_cnt_in    = div_cnt_ff;
      next_idx_in   = next_idx_ff;
      cur_idx_in    = cur_idx_ff;
      clr_idx_in    = clr_idx_ff;
      prod1_in      = prod1_ff;
      diff_in       = diff_ff;
      prod2_in      = prod2_ff;
      levels_in     = levels_ff;
      disc_in       = disc_ff;
      lr_in         = lr_ff;
      expl_in       = expl_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_action_in = rsp_action_ff;
      rsp_greedy_in = rsp_greedy_ff;
      rsp_knob_in   = rsp_knob_ff;
      ram_we        = 1'b0;
      ram_waddr     = cur_idx_ff;
      ram_wdata     = '0;
      ram_raddr     = target_idx(act_ff);

      cnt    = 4'd1;
      trial  = {rem_ff, dvd_ff[td0gta_pkg::PICK_W-1]};
      reward = $signed({1'b0, perf_ff}) - $signed({1'b0, last_perf_ff});
      sample = 26'(reward) + 26'($signed(prod1_ff[32:8]));
      upd    = 29'(cur_val_ff) + 29'($signed(prod2_ff[35:8]));
      k      = (chosen_ff - ACT_W'(1)) >> 1;

      for (int i = 0; i < NUM_KNOBS; i++) begin
         cnt = cnt + 4'(levels_ff[i] != LW'(LEVELS - 1)) + 4'(levels_ff[i] != '0);
      end

      if (csr_wr_en) begin
         unique case (csr_index)
            td0gta_pkg::CSR_DISCOUNT:   disc_in = csr_wdata;
            td0gta_pkg::CSR_LEARN_RATE: lr_in   = csr_wdata;
            td0gta_pkg::CSR_EXPLORE:    expl_in = csr_wdata[td0gta_pkg::PCT_W-1:0];
            default: ;
         endcase
      end

      // random pick modulo allowed count, one quotient bit per cycle
      if (!div_done) begin
         if (trial >= {1'b0, count_ff}) begin
            rem_in = 4'(trial - {1'b0, count_ff});
         end else begin
            rem_in = trial[3:0];
         end
         dvd_in     = dvd_ff << 1;
         div_cnt_in = div_cnt_ff + 4'd1;
      end

      // greedy compare of the read issued last cycle
      if (rd_pend_ff) begin
         if (rd_act_ff == '0 || rd_sdata > best_val_ff) begin
            best_val_in = rd_sdata;
            best_act_in = rd_act_ff;
         end
         if (rd_act_ff == '0) begin
            cur_val_in = rd_sdata;
         end
      end

      unique case (state_ff)
         td0gta_pkg::ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_idx_ff;
            clr_idx_in = clr_idx_ff + IW'(1);
         end
         td0gta_pkg::ST_IDLE: begin
            if (req_fire) begin
               act_in     = '0;
               perf_in    = req_port.performance;
               greedy_in  = (8'(req_port.random_percent) + 8'(expl_ff))
                            < td0gta_pkg::GREEDY_BOUND;
               count_in   = cnt;
               dvd_in     = req_port.random_pick;
               rem_in     = '0;
               div_cnt_in = '0;
            end
         end
         td0gta_pkg::ST_SCAN: begin
            rd_pend_in = act_allowed(act_ff);
            act_in     = scan_last ? '0 : act_ff + ACT_W'(1);
         end
         td0gta_pkg::ST_SCAN_LAST: begin
            if (greedy_ff) begin
               chosen_in = best_act_in;
            end
         end
         td0gta_pkg::ST_PICK: begin
            if (div_done) begin
               act_in = act_ff + ACT_W'(1);
               if (act_allowed(act_ff)) begin
                  if (rem_ff == '0) begin
                     chosen_in = act_ff;
                  end else begin
                     rem_in = rem_ff - 4'd1;
                  end
               end
            end
         end
         td0gta_pkg::ST_READ_NEXT: begin
            ram_raddr   = target_idx(chosen_ff);
            next_idx_in = target_idx(chosen_ff);
         end
         td0gta_pkg::ST_MUL1: begin
            prod1_in = $signed({1'b0, disc_ff}) * rd_sdata;
         end
         td0gta_pkg::ST_MUL2: begin
            diff_in = 27'(sample) - 27'(cur_val_ff);
         end
         td0gta_pkg::ST_MUL3: begin
            prod2_in = $signed({1'b0, lr_ff}) * diff_ff;
         end
         td0gta_pkg::ST_UPDATE: begin
            ram_we = 1'b1;
            priority if (upd > td0gta_pkg::VAL_MAX) begin
               ram_wdata = VAL_W'(td0gta_pkg::VAL_MAX);
            end else if (upd < td0gta_pkg::VAL_MIN) begin
               ram_wdata = VAL_W'(td0gta_pkg::VAL_MIN);
            end else begin
               ram_wdata = VAL_W'(upd);
            end
            for (int i = 0; i < NUM_KNOBS; i++) begin
               if (chosen_ff != '0 && k == ACT_W'(i)) begin
                  levels_in[i] = chosen_ff[0] ? levels_ff[i] + LW'(1)
                                              : levels_ff[i] - LW'(1);
               end
            end
            cur_idx_in   = next_idx_ff;
            last_perf_in = perf_ff;
         end
         td0gta_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_action_in = chosen_ff;
               rsp_greedy_in = greedy_ff;
               for (int i = 0; i < 4; i++) begin
                  rsp_knob_in[i] = '0;
                  if (i < NUM_KNOBS) begin
                     rsp_knob_in[i] = td0gta_pkg::LVL_OUT_W'(levels_ff[i]);
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= td0gta_pkg::ST_CLEAR;
         clr_idx_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         div_cnt_ff   <= td0gta_pkg::DIV_STEPS;
         cur_idx_ff   <= '0;
         last_perf_ff <= '0;
         disc_ff      <= td0gta_pkg::DISCOUNT_RST;
         lr_ff        <= td0gta_pkg::LEARN_RATE_RST;
         expl_ff      <= td0gta_pkg::EXPLORE_RST;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_KNOBS; i++) begin
            levels_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rd_pend_ff   <= rd_pend_in;
         div_cnt_ff   <= div_cnt_in;
         cur_idx_ff   <= cur_idx_in;
         last_perf_ff <= last_perf_in;
         disc_ff      <= disc_in;
         lr_ff        <= lr_in;
         expl_ff      <= expl_in;
         rsp_valid_ff <= rsp_valid_in;
         levels_ff    <= levels_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      rd_act_ff     <= rd_act_in;
      best_act_ff   <= best_act_in;
      best_val_ff   <= best_val_in;
      cur_val_ff    <= cur_val_in;
      chosen_ff     <= chosen_in;
      greedy_ff     <= greedy_in;
      perf_ff       <= perf_in;
      count_ff      <= count_in;
      rem_ff        <= rem_in;
      dvd_ff        <= dvd_in;
      next_idx_ff   <= next_idx_in;
      prod1_ff      <= prod1_in;
      diff_ff       <= diff_in;
      prod2_ff      <= prod2_in;
      rsp_action_ff <= rsp_action_in;
      rsp_greedy_ff <= rsp_greedy_in;
      rsp_knob_ff   <= rsp_knob_in;
   end

   td0gta_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_value_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.action      = rsp_action_ff;
   assign rsp_port.was_greedy  = rsp_greedy_ff;
   assign rsp_port.knob0_level = rsp_knob_ff[0];
   assign rsp_port.knob1_level = rsp_knob_ff[1];
   assign rsp_port.knob2_level = rsp_knob_ff[2];
   assign rsp_port.knob3_level = rsp_knob_ff[3];

`ifndef NO_ASSERTIONS
   a_chosen_allowed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == td0gta_pkg::ST_READ_NEXT) |-> act_allowed(chosen_ff))
      else $error("chosen action is not allowed");

   a_rem_below_count: assert property (@(posedge clock) disable iff (reset)
      (div_done && state_ff == td0gta_pkg::ST_PICK) |-> (rem_ff < count_ff))
      else $error("random pick remainder not below allowed count");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == td0gta_pkg::ST_DONE))
      else $error("response raised outside the done state");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == td0gta_pkg::ST_SCAN
                      || state_ff == td0gta_pkg::ST_SCAN_LAST))
      else $error("scan read pending outside the scan");
`endif

endmodule

// File: rtl/core/td0gta_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// td0gta_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module td0gta_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for td0_grid_tuning_agent
// A clocked driver feeds performance requests from a queue, and a clocked
// monitor predicts each move from its own copy of the value table, knob levels
// and settings, then checks every response field against the oldest prediction.
// Phases change the discount, learn rate and explore settings while the block
// is idle, and three back-pressure modes alternate on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import td0gta_pkg::*;

   localparam int KNOBS  = 4;
   localparam int LVLS   = 4;
   localparam int DEPTH  = 256;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [ACT_W-1:0] {
      ACT_STAY, ACT_RAISE0, ACT_LOWER0, ACT_RAISE1, ACT_LOWER1,
      ACT_RAISE2, ACT_LOWER2, ACT_RAISE3, ACT_LOWER3
   } move_code_t;

   typedef struct {
      logic [PERF_W-1:0] perf;
      logic [PCT_W-1:0]  pct;
      logic [PICK_W-1:0] pick;
      bit                drain;
   } perf_req_t;

   typedef struct {
      logic [ACT_W-1:0]     action;
      logic                 was_greedy;
      logic [LVL_OUT_W-1:0] lvl [KNOBS];
   } agent_move_t;

   logic clock;
   logic reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   td0gta_req_if req_bus ();
   td0gta_rsp_if rsp_bus ();

   td0_grid_tuning_agent #(.NUM_KNOBS(KNOBS), .LEVELS(LVLS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus),
      .rsp_port  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic signed [VAL_W-1:0] value_est [DEPTH];
   int                      knob_lvl [KNOBS];
   int                      grid_pos;
   logic [PERF_W-1:0]       last_perf_q;
   logic [7:0]              gamma_r;
   logic [7:0]              alpha_r;
   logic [PCT_W-1:0]        eps_r;

   perf_req_t   perf_samples [$];
   agent_move_t expected_moves [$];

   int  errors = 0;
   int  n_req = 0;
   int  n_rsp = 0;
   int  n_greedy = 0;
   int  n_settings = 1;
   bit  move_seen [9];
   int  send_idle = 0;
   int  recv_idle = 0;
   logic req_fire = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("td0_grid_tuning_agent: mismatch");
      $finish;
   end

   function automatic bit move_ok(int a);
      int k;
      if (a == ACT_STAY) return 1'b1;
      k = (a - 1) / 2;
      if (a % 2 == 1) return knob_lvl[k] + 1 < LVLS;
      return knob_lvl[k] > 0;
   endfunction

   function automatic int move_target(int a);
      int k, stride;
      if (a == ACT_STAY) return grid_pos;
      k = (a - 1) / 2;
      stride = 1;
      repeat (k) stride *= LVLS;
      if (a % 2 == 1) return grid_pos + stride;
      return grid_pos - stride;
   endfunction

   function automatic agent_move_t predict_move(perf_req_t s);
      agent_move_t m;
      int a, best, count, sel, left, nxt, k;
      longint v, best_v, reward, sample, cur, upd;
      bit greedy;
      best = ACT_STAY;
      best_v = 0;
      count = 0;
      for (a = ACT_STAY; a <= ACT_LOWER3; a++) begin
         if (move_ok(a)) begin
            count++;
            v = value_est[move_target(a)];
            if (a == ACT_STAY || v > best_v) begin
               best_v = v;
               best = a;
            end
         end
      end
      greedy = int'(s.pct) < 100 - int'(eps_r);
      sel = ACT_STAY;
      if (greedy) begin
         sel = best;
      end else begin
         left = int'(s.pick) % count;
         for (a = ACT_STAY; a <= ACT_LOWER3; a++) begin
            if (move_ok(a)) begin
               if (left == 0) begin
                  sel = a;
                  break;
               end
               left--;
            end
         end
      end
      nxt = move_target(sel);
      if (sel != ACT_STAY) begin
         k = (sel - 1) / 2;
         if (sel % 2 == 1) knob_lvl[k]++;
         else knob_lvl[k]--;
      end
      // TD(0): target entry read before the current one is written
      reward = longint'(s.perf) - longint'(last_perf_q);
      last_perf_q = s.perf;
      sample = reward + ((longint'(gamma_r) * longint'(value_est[nxt])) >>> 8);
      cur = value_est[grid_pos];
      upd = cur + ((longint'(alpha_r) * (sample - cur)) >>> 8);
      if (upd > 64'sd8388607) upd = 64'sd8388607;
      if (upd < -64'sd8388608) upd = -64'sd8388608;
      value_est[grid_pos] = upd[VAL_W-1:0];
      grid_pos = nxt;
      m.action = sel[ACT_W-1:0];
      m.was_greedy = greedy;
      for (k = 0; k < KNOBS; k++) m.lvl[k] = knob_lvl[k][LVL_OUT_W-1:0];
      if (greedy) n_greedy++;
      move_seen[sel] = 1'b1;
      return m;
   endfunction

   task automatic cmp_field(input string fname, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("t=%0t %s: expected %0d, actual %0d", $time, fname, want, got);
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_fire) begin
         req_bus.valid <= 1'b1;
      end else if (perf_samples.size() != 0
                   && !(perf_samples[0].drain && expected_moves.size() != 0)
                   && $urandom_range(0, 99) >= send_idle) begin
         req_bus.valid          <= 1'b1;
         req_bus.performance    <= perf_samples[0].perf;
         req_bus.random_percent <= perf_samples[0].pct;
         req_bus.random_pick    <= perf_samples[0].pick;
         perf_samples.pop_front();
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(0, 99) >= recv_idle);
   end

   // monitor: predict on request, check on response
   always @(posedge clock) begin
      agent_move_t want;
      perf_req_t   s;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            n_rsp++;
            if (expected_moves.size() == 0) begin
               errors++;
               $display("t=%0t response with none outstanding: action %0d",
                        $time, rsp_bus.action);
            end else begin
               want = expected_moves.pop_front();
               cmp_field("action", want.action, rsp_bus.action);
               cmp_field("was_greedy", want.was_greedy, rsp_bus.was_greedy);
               cmp_field("knob0_level", want.lvl[0], rsp_bus.knob0_level);
               cmp_field("knob1_level", want.lvl[1], rsp_bus.knob1_level);
               cmp_field("knob2_level", want.lvl[2], rsp_bus.knob2_level);
               cmp_field("knob3_level", want.lvl[3], rsp_bus.knob3_level);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            s.perf  = req_bus.performance;
            s.pct   = req_bus.random_percent;
            s.pick  = req_bus.random_pick;
            s.drain = 1'b0;
            expected_moves.push_back(predict_move(s));
            n_req++;
         end
      end
   end

   task automatic add_req(input int perf, input int pct, input int pick, input bit drain = 0);
      perf_req_t s;
      s.perf  = perf[PERF_W-1:0];
      s.pct   = pct[PCT_W-1:0];
      s.pick  = pick[PICK_W-1:0];
      s.drain = drain;
      perf_samples.push_back(s);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_DISCOUNT:   gamma_r = data;
         CSR_LEARN_RATE: alpha_r = data;
         CSR_EXPLORE:    eps_r = data[PCT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      while (perf_samples.size() != 0 || expected_moves.size() != 0 || req_bus.valid)
         @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   initial begin
      int i, ph, tmp;
      logic [PERF_W-1:0] p;
      logic [7:0] d, l;
      logic [PCT_W-1:0] e;

      req_bus.valid          = 1'b0;
      req_bus.performance    = '0;
      req_bus.random_percent = '0;
      req_bus.random_pick    = '0;
      rsp_bus.ready          = 1'b0;
      for (i = 0; i < DEPTH; i++) value_est[i] = '0;
      for (i = 0; i < KNOBS; i++) knob_lvl[i] = 0;
      grid_pos    = 0;
      last_perf_q = '0;
      gamma_r     = DISCOUNT_RST;
      alpha_r     = LEARN_RATE_RST;
      eps_r       = EXPLORE_RST;
      send_idle   = 33;
      recv_idle   = 60;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: greedy edge, explore edge, out-of-range percent
      add_req(0, 0, 0);
      add_req(65535, 0, 0);
      add_req(0, 79, 255);
      add_req(1234, 80, 0);
      add_req(65535, 100, 255);
      add_req(0, 127, 170);
      wait_idle();

      // max weights, greedy for percents below 100, swinging performance
      write_reg(CSR_DISCOUNT, 8'd255);
      write_reg(CSR_LEARN_RATE, 8'd255);
      write_reg(CSR_EXPLORE, 8'd0);
      n_settings++;
      for (i = 0; i < 8; i++) add_req(i % 2 ? 0 : 65535, i % 2 ? 0 : 99, 85);
      add_req(65535, 100, 3);
      wait_idle();

      // zero weights, bound at zero: all explore; unused index ignored
      write_reg(CSR_UNUSED, 8'hA5);
      write_reg(CSR_DISCOUNT, 8'd0);
      write_reg(CSR_LEARN_RATE, 8'd0);
      write_reg(CSR_EXPLORE, 8'd100);
      n_settings++;
      add_req(100, 0, 1);
      add_req(200, 0, 2);
      add_req(300, 0, 3);
      add_req(400, 50, 4);
      add_req(500, 99, 8);
      add_req(600, 0, 255, 1);
      add_req(700, 0, 0);
      wait_idle();

      // explore above 100 (top data bit masked off)
      write_reg(CSR_EXPLORE, 8'hFF);
      n_settings++;
      add_req(65535, 0, 7);
      add_req(0, 0, 6);
      add_req(32768, 64, 5);
      wait_idle();

      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin d = $urandom_range(0, 255); l = $urandom_range(1, 255);
                  e = $urandom_range(5, 60); end
            1: begin d = 8'd0; l = 8'd255; e = 7'd30; end
            2: begin d = 8'd255; l = 8'd0; e = $urandom_range(0, 100); end
            3: begin d = $urandom_range(0, 255); l = $urandom_range(0, 255); e = 7'd0; end
            4: begin d = 8'd255; l = 8'd255; e = $urandom_range(101, 127); end
            default: begin d = DISCOUNT_RST; l = LEARN_RATE_RST; e = EXPLORE_RST; end
         endcase
         write_reg(CSR_DISCOUNT, d);
         write_reg(CSR_LEARN_RATE, l);
         write_reg(CSR_EXPLORE, {1'b0, e});
         n_settings++;
         if (ph < 2) begin
            send_idle = 33;
            recv_idle = 60;
         end else if (ph < 4) begin
            send_idle = 60;
            recv_idle = 33;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         p = $urandom_range(0, 65535);
         for (i = 0; i < 250; i++) begin
            case ($urandom_range(0, 3))
               0: p = $urandom_range(0, 65535);
               3: p = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               default: begin
                  tmp = int'(p) + int'($urandom_range(0, 1024)) - 512;
                  if (tmp < 0) tmp = 0;
                  if (tmp > 65535) tmp = 65535;
                  p = tmp[PERF_W-1:0];
               end
            endcase
            add_req(p, $urandom_range(0, 99) < 85 ? $urandom_range(0, 100)
                                                   : $urandom_range(0, 127),
                    $urandom_range(0, 255), $urandom_range(0, 39) == 0);
         end
         wait_idle();
      end

      repeat (40) @(posedge clock);
      $display("Run: %0d requests, %0d responses, %0d register settings.",
               n_req, n_rsp, n_settings);
      $display("Moves: %0d greedy, %0d explored; all nine move codes seen: %0d.",
               n_greedy, n_req - n_greedy, move_seen.and());
      if (errors == 0 && expected_moves.size() == 0)
         $display("td0_grid_tuning_agent: match");
      else
         $display("td0_grid_tuning_agent: mismatch");
      $finish;
   end

endmodule

// File: files.f
rtl/core/td0gta_pkg.sv
rtl/core/td0gta_ifs.sv
rtl/core/td0gta_ram.sv
rtl/core/td0_grid_tuning_agent.sv
tb/sv/testbench.sv
